@@ src/rhe_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the region equalizer.
package rhe_pkg;

   localparam int REGION_SLOTS = 64;
   localparam int BIN_COUNT    = 256;
   localparam int MAX_PIXELS   = 1048576;

   localparam int REG_W     = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int BIN_W     = $clog2(BIN_COUNT);
   localparam int ADDR_W    = REG_W + BIN_W;
   localparam int CNT_W     = $clog2(MAX_PIXELS + 1);
   localparam int GREY_W    = 8;
   localparam int NUM_W     = CNT_W + GREY_W;
   localparam int STEP_W    = 3;

   typedef enum logic [1:0] {
      OP_ACC   = 2'd0,
      OP_FIN   = 2'd1,
      OP_LOOK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_PHASE = 2'd1,
      ST_RANGE = 2'd2,
      ST_CAP   = 2'd3
   } status_type;

   typedef struct packed {
      logic load_item;
      logic res_load;
      logic clr_start;
      logic clr_step;
      logic acc_rd;
      logic acc_wr;
      logic look_rd;
      logic look_res;
      logic fin_start;
      logic r_inc;
      logic fin_rd0;
      logic pre_step;
      logic sc_rd;
      logic sc_load;
      logic div_step;
      logic sc_wr;
      logic b_inc;
      logic set_ready;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      op_type     op;
      status_type st;
      logic       seen_cur;
      logic       seen_r;
      logic       r_last;
      logic       b_last;
      logic       k_last;
      logic       clr_last;
   } sts_type;

endpackage

@@ src/rhe_dpath.sv @@
// Datapath: bin memory, region flags, counters, scaling divider and result registers.
module rhe_dpath (
   input  logic              clock,
   input  logic              reset,
   input  rhe_pkg::cmd_type  cmd,
   output rhe_pkg::sts_type  sts,
   input  logic [23:0]       req_tdata,
   output logic [15:0]       rsp_tdata
);
   import rhe_pkg::*;

   logic [CNT_W-1:0]  mem [2**ADDR_W];
   logic [CNT_W-1:0]  rd_ff;

   logic [1:0]        op_ff;
   logic [9:0]        id_ff;
   logic [BIN_W-1:0]  bin_ff;
   logic [GREY_W-1:0] grey;

   logic [REGION_SLOTS-1:0] seen_ff, seen_in;
   logic              ready_ff, ready_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [REG_W-1:0]  r_ff, r_in;
   logic [BIN_W-1:0]  b_ff, b_in, b_nx;
   logic [CNT_W-1:0]  acc_ff, acc_in, acc_sum;
   logic [CNT_W-1:0]  div_ff;
   logic [NUM_W-1:0]  rem_ff, rem_in, dshift;
   logic [GREY_W-1:0] q_ff, q_in;
   logic [STEP_W-1:0] k_ff, k_in;

   logic [GREY_W-1:0] res_map_ff;
   logic              res_known_ff;
   logic [1:0]        res_st_ff;
   logic [GREY_W-1:0] out_map_ff;
   logic              out_known_ff;
   logic [1:0]        out_st_ff;

   logic              we, re;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [CNT_W-1:0]  wdata;
   logic [REG_W-1:0]  reg_idx;
   logic              range_bad;
   status_type        st;

   assign grey      = req_tdata[19:12];
   assign reg_idx   = id_ff[REG_W-1:0];
   assign range_bad = {1'b0, id_ff} >= 11'(REGION_SLOTS);
   assign acc_sum   = acc_ff + rd_ff;
   assign b_nx      = b_ff + 1'b1;
   assign dshift    = NUM_W'(div_ff) << k_ff;

   always_comb begin
      st = ST_OK;
      case (op_type'(op_ff))
         OP_ACC: begin
            if (ready_ff) st = ST_PHASE;
            else if (range_bad) st = ST_RANGE;
            else if (total_ff >= CNT_W'(MAX_PIXELS)) st = ST_CAP;
         end
         OP_FIN: begin
            if (ready_ff) st = ST_PHASE;
         end
         OP_LOOK: begin
            if (!ready_ff) st = ST_PHASE;
            else if (range_bad) st = ST_RANGE;
         end
         default: st = ST_OK;
      endcase
   end

   assign sts.op       = op_type'(op_ff);
   assign sts.st       = st;
   assign sts.seen_cur = seen_ff[reg_idx];
   assign sts.seen_r   = seen_ff[r_ff];
   assign sts.r_last   = r_ff == REG_W'(REGION_SLOTS - 1);
   assign sts.b_last   = b_ff == BIN_W'(BIN_COUNT - 1);
   assign sts.k_last   = k_ff == '0;
   assign sts.clr_last = &clr_ff;

   // Memory port selection.
   always_comb begin
      we    = 1'b0;
      waddr = {r_ff, b_ff};
      wdata = '0;
      re    = 1'b0;
      raddr = {r_ff, b_ff};
      if (cmd.clr_step) begin
         we    = 1'b1;
         waddr = clr_ff;
      end
      if (cmd.acc_wr) begin
         we    = 1'b1;
         waddr = {reg_idx, bin_ff};
         wdata = rd_ff + 1'b1;
      end
      if (cmd.pre_step) begin
         we    = 1'b1;
         wdata = acc_sum;
         re    = 1'b1;
         raddr = {r_ff, b_nx};
      end
      if (cmd.sc_wr) begin
         we    = 1'b1;
         wdata = CNT_W'(q_ff);
      end
      if (cmd.acc_rd || cmd.look_rd) begin
         re    = 1'b1;
         raddr = {reg_idx, bin_ff};
      end
      if (cmd.fin_rd0) begin
         re    = 1'b1;
         raddr = {r_ff, BIN_W'(0)};
      end
      if (cmd.sc_rd) re = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rd_ff <= mem[raddr];
   end

   always_comb begin
      seen_in  = seen_ff;
      ready_in = ready_ff;
      total_in = total_ff;
      clr_in   = clr_ff;
      r_in     = r_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      k_in     = k_ff;
      if (cmd.clr_start) begin
         seen_in  = '0;
         ready_in = 1'b0;
         total_in = '0;
         clr_in   = '0;
      end
      if (cmd.clr_step) clr_in = clr_ff + 1'b1;
      if (cmd.acc_wr) begin
         seen_in[reg_idx] = 1'b1;
         total_in         = total_ff + 1'b1;
      end
      if (cmd.set_ready) ready_in = 1'b1;
      if (cmd.fin_start) r_in = '0;
      if (cmd.r_inc) r_in = r_ff + 1'b1;
      if (cmd.fin_rd0) begin
         b_in   = '0;
         acc_in = '0;
      end
      if (cmd.pre_step) begin
         acc_in = acc_sum;
         b_in   = sts.b_last ? BIN_W'(0) : b_nx;
      end
      if (cmd.b_inc) b_in = b_nx;
      // Scale by full scale as (x << 8) - x, then divide one quotient bit a cycle.
      if (cmd.sc_load) begin
         rem_in = {rd_ff, GREY_W'(0)} - NUM_W'(rd_ff);
         q_in   = '0;
         k_in   = STEP_W'(GREY_W - 1);
      end
      if (cmd.div_step) begin
         if (rem_ff >= dshift) begin
            rem_in = rem_ff - dshift;
            q_in   = {q_ff[GREY_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[GREY_W-2:0], 1'b0};
         end
         k_in = k_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         ready_ff <= 1'b0;
         total_ff <= '0;
         clr_ff   <= '0;
         r_ff     <= '0;
         b_ff     <= '0;
         k_ff     <= '0;
      end else begin
         seen_ff  <= seen_in;
         ready_ff <= ready_in;
         total_ff <= total_in;
         clr_ff   <= clr_in;
         r_ff     <= r_in;
         b_ff     <= b_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (cmd.pre_step && sts.b_last) div_ff <= acc_sum;
      if (cmd.load_item) begin
         op_ff  <= req_tdata[1:0];
         id_ff  <= req_tdata[11:2];
         bin_ff <= ({1'b0, grey} >= 9'(BIN_COUNT)) ? BIN_W'(BIN_COUNT - 1)
                                                   : grey[BIN_W-1:0];
      end
      if (cmd.res_load) begin
         res_map_ff   <= '0;
         res_known_ff <= (op_type'(op_ff) == OP_ACC) && (st == ST_CAP) && seen_ff[reg_idx];
         res_st_ff    <= st;
      end
      if (cmd.acc_wr) res_known_ff <= 1'b1;
      if (cmd.look_res) begin
         res_map_ff   <= rd_ff[GREY_W-1:0];
         res_known_ff <= 1'b1;
      end
      if (cmd.out_load) begin
         out_map_ff   <= res_map_ff;
         out_known_ff <= res_known_ff;
         out_st_ff    <= res_st_ff;
      end
   end

   assign rsp_tdata = {5'b0, out_st_ff, out_known_ff, out_map_ff};

endmodule

@@ src/rhe_ctrl.sv @@
// Controller: sequences accumulate, lookup, finalize and clear passes.
module rhe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  rhe_pkg::sts_type  sts,
   output rhe_pkg::cmd_type  cmd
);
   import rhe_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_EXEC   = 12'b000000000010,
      S_CLEAR  = 12'b000000000100,
      S_ACC_WR = 12'b000000001000,
      S_LOOK   = 12'b000000010000,
      S_FIN    = 12'b000000100000,
      S_PRE    = 12'b000001000000,
      S_SC_RD  = 12'b000010000000,
      S_SC_LD  = 12'b000100000000,
      S_SC_DIV = 12'b001000000000,
      S_SC_WR  = 12'b010000000000,
      S_RESP   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      reply_ff, reply_in;
   logic      valid_ff, valid_in;

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      reply_in = reply_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.res_load = 1'b1;
            if (sts.op == OP_CLEAR) begin
               cmd.clr_start = 1'b1;
               reply_in      = 1'b1;
               state_in      = S_CLEAR;
            end else if (sts.st != ST_OK) begin
               state_in = S_RESP;
            end else begin
               case (sts.op)
                  OP_ACC: begin
                     cmd.acc_rd = 1'b1;
                     state_in   = S_ACC_WR;
                  end
                  OP_FIN: begin
                     cmd.fin_start = 1'b1;
                     state_in      = S_FIN;
                  end
                  OP_LOOK: begin
                     if (sts.seen_cur) begin
                        cmd.look_rd = 1'b1;
                        state_in    = S_LOOK;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = reply_ff ? S_RESP : S_IDLE;
               reply_in = 1'b0;
            end
         end
         S_ACC_WR: begin
            cmd.acc_wr = 1'b1;
            state_in   = S_RESP;
         end
         S_LOOK: begin
            cmd.look_res = 1'b1;
            state_in     = S_RESP;
         end
         S_FIN: begin
            if (!sts.seen_r) begin
               if (sts.r_last) begin
                  cmd.set_ready = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  cmd.r_inc = 1'b1;
               end
            end else begin
               cmd.fin_rd0 = 1'b1;
               state_in    = S_PRE;
            end
         end
         S_PRE: begin
            cmd.pre_step = 1'b1;
            if (sts.b_last) state_in = S_SC_RD;
         end
         S_SC_RD: begin
            cmd.sc_rd = 1'b1;
            state_in  = S_SC_LD;
         end
         S_SC_LD: begin
            cmd.sc_load = 1'b1;
            state_in    = S_SC_DIV;
         end
         S_SC_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.k_last) state_in = S_SC_WR;
         end
         S_SC_WR: begin
            cmd.sc_wr = 1'b1;
            if (sts.b_last) begin
               if (sts.r_last) begin
                  cmd.set_ready = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  cmd.r_inc = 1'b1;
                  state_in  = S_FIN;
               end
            end else begin
               cmd.b_inc = 1'b1;
               state_in  = S_SC_RD;
            end
         end
         S_RESP: begin
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         reply_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
         valid_ff <= valid_in;
      end
   end

endmodule

@@ src/region_histogram_equalizer_core.sv @@
// Top level of the per-region histogram equalizer: controller, datapath and checks.
// Clear zeroes one bin-memory entry per cycle. Finalize skips unseen regions; for a seen
// region it runs a prefix sweep over its 256 bins, then per bin a read, a scale and an
// 8-step shift-subtract divide. One item is in flight at a time; the next beat is taken
// once the result sits in the output register.
// Reset is synchronous: after reset all 16384 entries are cleared with req_tready low.
module region_histogram_equalizer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // op[1:0], region[11:2], intensity[19:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // mapped_intensity[7:0], region_known[8], status[10:9]
);
   import rhe_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequence each beat through the state machine.
   rhe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Hold the bin memory, flags, divider and result registers.
   rhe_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

   // No beat is taken while the memory is being cleared.
   assert property (@(posedge clock) disable iff (reset) cmd.clr_step |-> !req_tready)
      else $error("beat accepted during clearing pass");

   // Only one memory read source per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.acc_rd, cmd.look_rd, cmd.fin_rd0, cmd.pre_step, cmd.sc_rd}))
      else $error("conflicting memory reads");

   // An accepted beat blocks the next one until its result is done.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat accepted while busy");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the per-region histogram equalizer core.
module testbench;
   import rhe_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int IDLE_PCT       = 37;
   localparam int ITEM_GOAL      = 1400;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      op_type     op;
      logic [9:0] region;
      logic [7:0] level;
      bit         drain;   // not a beat: hold the sender until all results are back
   } pixel_cmd;

   typedef struct {
      logic [7:0] mapped;
      logic       known;
      status_type status;
   } equalizer_rsp;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // op[1:0], region[11:2], intensity[19:12]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // mapped_intensity[7:0], region_known[8], status[10:9]

   region_histogram_equalizer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Shadow copy of the block state used by the predictor.
   int unsigned shadow_bins [REGION_SLOTS][BIN_COUNT];
   bit          shadow_seen [REGION_SLOTS];
   bit          shadow_ready;
   int unsigned shadow_total;

   pixel_cmd     pending_cmds[$];
   equalizer_rsp expected_rsps[$];
   pixel_cmd     cmd_on_bus;

   int  mismatches;
   int  beats_sent;
   int  beats_checked;
   int  op_counts [4];
   int  quiet_cycles;
   bit  driver_calm;    // no idling stretch on the sender
   bit  monitor_calm;   // no stalling stretch on the receiver

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic clear_shadow();
      for (int r = 0; r < REGION_SLOTS; r++) begin
         shadow_seen[r] = 1'b0;
         for (int b = 0; b < BIN_COUNT; b++) shadow_bins[r][b] = 0;
      end
      shadow_ready = 1'b0;
      shadow_total = 0;
   endtask

   // Turn each seen histogram into a scaled cumulative table.
   task automatic build_tables();
      longint unsigned total;
      for (int r = 0; r < REGION_SLOTS; r++) begin
         if (shadow_seen[r]) begin
            for (int b = 1; b < BIN_COUNT; b++)
               shadow_bins[r][b] += shadow_bins[r][b-1];
            total = longint'(shadow_bins[r][BIN_COUNT-1]);
            if (total != 0)
               for (int b = 0; b < BIN_COUNT; b++)
                  shadow_bins[r][b] =
                     int'((longint'(shadow_bins[r][b]) * 255) / total);
         end
      end
   endtask

   task automatic equalize_step(input pixel_cmd c, output equalizer_rsp res);
      int bin;
      bin = (c.level >= BIN_COUNT) ? BIN_COUNT - 1 : c.level;
      res.mapped = '0;
      res.known  = 1'b0;
      res.status = ST_OK;
      case (c.op)
         OP_CLEAR: clear_shadow();
         OP_ACC: begin
            if (shadow_ready) res.status = ST_PHASE;
            else if (c.region >= REGION_SLOTS) res.status = ST_RANGE;
            else if (shadow_total >= MAX_PIXELS) begin
               res.status = ST_CAP;
               res.known  = shadow_seen[c.region];
            end else begin
               shadow_bins[c.region][bin]++;
               shadow_seen[c.region] = 1'b1;
               shadow_total++;
               res.known = 1'b1;
            end
         end
         OP_FIN: begin
            if (shadow_ready) res.status = ST_PHASE;
            else begin
               build_tables();
               shadow_ready = 1'b1;
            end
         end
         default: begin
            if (!shadow_ready) res.status = ST_PHASE;
            else if (c.region >= REGION_SLOTS) res.status = ST_RANGE;
            else if (shadow_seen[c.region]) begin
               res.known  = 1'b1;
               res.mapped = shadow_bins[c.region][bin][7:0];
            end
         end
      endcase
   endtask

   function automatic pixel_cmd mk(op_type op, int region, int level);
      pixel_cmd c;
      c.op     = op;
      c.region = region[9:0];
      c.level  = level[7:0];
      c.drain  = 1'b0;
      return c;
   endfunction

   function automatic pixel_cmd drain_mark();
      pixel_cmd c;
      c = mk(OP_CLEAR, 0, 0);
      c.drain = 1'b1;
      return c;
   endfunction

   // Append one command to the tail of the pending queue.
   function automatic void add_cmd(pixel_cmd c);
      pending_cmds = {pending_cmds, c};
   endfunction

   // Driver: present the next command when the bus is free, idling at random.
   always @(posedge clock) begin
      equalizer_rsp res;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            equalize_step(cmd_on_bus, res);
            expected_rsps = {expected_rsps, res};
            op_counts[cmd_on_bus.op]++;
            beats_sent++;
         end
         if (!req_tvalid || req_tready) begin
            // drop a drain marker once everything in flight has returned
            if (pending_cmds.size() > 0 && pending_cmds[0].drain &&
                expected_rsps.size() == 0 && !req_tvalid)
               void'(pending_cmds.pop_front());
            driver_calm = (beats_sent >= 300 && beats_sent < 500);
            if (pending_cmds.size() > 0 && !pending_cmds[0].drain &&
                (driver_calm || $urandom_range(99) >= IDLE_PCT)) begin
               cmd_on_bus = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, cmd_on_bus.level, cmd_on_bus.region, cmd_on_bus.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, check every accepted result in order.
   always @(posedge clock) begin
      equalizer_rsp want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            beats_checked++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("ERROR: unexpected result beat %h", rsp_tdata);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tdata[7:0] !== want.mapped || rsp_tdata[8] !== want.known ||
                   rsp_tdata[10:9] !== want.status) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"ERROR: result %0d mapped/known/status ",
                               "exp %0d/%0d/%0d got %0d/%0d/%0d"},
                              beats_checked, want.mapped, want.known, want.status,
                              rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[10:9]);
               end
            end
         end
         monitor_calm = (beats_checked >= 700 && beats_checked < 900);
         rsp_tready <= monitor_calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog: abort when no beat moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: watchdog expired with %0d results outstanding",
                  expected_rsps.size());
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int pick_unseen(int regions[$]);
      int r;
      bit hit;
      do begin
         r = $urandom_range(REGION_SLOTS - 1);
         hit = 1'b0;
         foreach (regions[i]) if (regions[i] == r) hit = 1'b1;
      end while (hit);
      return r;
   endfunction

   // Build one image: collect, finalize, look up, clear.
   task automatic queue_image();
      int regions[$];
      int nreg, n, pick;
      nreg = $urandom_range(4, 1);
      for (int i = 0; i < nreg; i++)
         regions = {regions, int'($urandom_range(REGION_SLOTS - 1))};
      n = $urandom_range(150, 60);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 88)
            add_cmd(mk(OP_ACC, regions[$urandom_range(nreg - 1)], $urandom_range(255)));
         else if (pick < 94)
            add_cmd(mk(OP_ACC, $urandom_range(1023, REGION_SLOTS), $urandom_range(255)));
         else
            add_cmd(mk(OP_LOOK, $urandom_range(1023), $urandom_range(255)));
      end
      add_cmd(mk(OP_FIN, $urandom_range(1023), $urandom_range(255)));
      n = $urandom_range(120, 60);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 80)
            add_cmd(mk(OP_LOOK, regions[$urandom_range(nreg - 1)], $urandom_range(255)));
         else if (pick < 88)
            add_cmd(mk(OP_LOOK, pick_unseen(regions), $urandom_range(255)));
         else if (pick < 94)
            add_cmd(mk(OP_LOOK, $urandom_range(1023, REGION_SLOTS), $urandom_range(255)));
         else if (pick < 97)
            add_cmd(mk(OP_ACC, $urandom_range(1023), $urandom_range(255)));
         else
            add_cmd(mk(OP_FIN, $urandom_range(1023), $urandom_range(255)));
         if ($urandom_range(199) == 0) add_cmd(drain_mark());
      end
      add_cmd(mk(OP_CLEAR, $urandom_range(1023), $urandom_range(255)));
   endtask

   initial begin
      int queued;
      mismatches    = 0;
      beats_sent    = 0;
      beats_checked = 0;
      quiet_cycles  = 0;
      driver_calm   = 1'b0;
      monitor_calm  = 1'b0;
      cmd_on_bus    = mk(OP_CLEAR, 0, 0);
      foreach (op_counts[i]) op_counts[i] = 0;
      clear_shadow();

      // Directed: field extremes, every op, phase and range rejections.
      add_cmd(mk(OP_LOOK, 0, 0));                   // lookup while collecting
      add_cmd(mk(OP_ACC, 0, 0));
      add_cmd(mk(OP_ACC, 0, 255));
      add_cmd(mk(OP_ACC, 63, 255));
      add_cmd(mk(OP_ACC, 63, 128));
      add_cmd(mk(OP_ACC, 63, 128));
      add_cmd(mk(OP_ACC, 64, 10));                  // just out of range
      add_cmd(mk(OP_ACC, 1023, 255));               // far out of range
      add_cmd(mk(OP_ACC, 21, 85));
      add_cmd(mk(OP_FIN, 1023, 255));
      add_cmd(mk(OP_FIN, 0, 0));                    // second finalize
      add_cmd(mk(OP_ACC, 0, 1));                    // counting when ready
      add_cmd(mk(OP_LOOK, 0, 0));
      add_cmd(mk(OP_LOOK, 0, 255));
      add_cmd(mk(OP_LOOK, 63, 127));
      add_cmd(mk(OP_LOOK, 63, 255));
      add_cmd(mk(OP_LOOK, 21, 84));
      add_cmd(mk(OP_LOOK, 5, 200));                 // unknown region
      add_cmd(mk(OP_LOOK, 64, 0));
      add_cmd(mk(OP_LOOK, 1023, 255));
      add_cmd(drain_mark());
      add_cmd(mk(OP_CLEAR, 1023, 255));
      add_cmd(mk(OP_LOOK, 0, 0));                   // tables gone after clear
      add_cmd(mk(OP_FIN, 0, 0));                    // finalize of nothing
      add_cmd(mk(OP_CLEAR, 0, 0));

      queued = pending_cmds.size();
      while (queued < ITEM_GOAL) begin
         queue_image();
         queued = pending_cmds.size();
      end

      @(negedge reset);
      while (pending_cmds.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Covered %0d beats: %0d accumulate, %0d finalize, %0d lookup, %0d clear;",
               beats_sent, op_counts[OP_ACC], op_counts[OP_FIN], op_counts[OP_LOOK],
               op_counts[OP_CLEAR]);
      $display("checked %0d results with %0d mismatches", beats_checked, mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
